[src/gsa_pkg.sv]
// gsa_pkg: shared constants, codes and types of the generational slot allocator
// depends on nothing; imported by gsa_ctrl and generational_slot_allocator
package gsa_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int GEN_BITS   = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int THR_W      = 13;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(512);

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_EXISTS  = 2'd2,
    CMD_FIND    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FAIL  = 2'd1,
    STAT_STALE = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FQ_WAIT,
    S_REUSE,
    S_CHECK,
    S_SCAN,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic                live;
    logic [GEN_BITS-1:0] gen;
  } slot_word_t;

  typedef struct packed {
    status_e             status;
    logic [GEN_BITS-1:0] generation;
    logic [IDX_W-1:0]    index;
  } result_t;

endpackage

[src/gsa_ram.sv]
// gsa_ram: generic single-clock ram, one write and one read port
// read data registered; no package dependency
module gsa_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[src/gsa_ctrl.sv]
// gsa_ctrl: command sequencer, counters and free-queue pointers
// drives read-modify-write on the slot ram and push and pop on the free-queue ram; uses gsa_pkg
module gsa_ctrl import gsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [THR_W-1:0]    thr_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [CMD_W-1:0]    req_cmd_i,
  input  logic [IDX_W-1:0]    req_index_i,
  input  logic [GEN_BITS-1:0] req_gen_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output result_t             res_o,
  output logic                slot_we_o,
  output logic [IDX_W-1:0]    slot_waddr_o,
  output slot_word_t          slot_wdata_o,
  output logic                slot_re_o,
  output logic [IDX_W-1:0]    slot_raddr_o,
  input  slot_word_t          slot_rdata_i,
  output logic                fq_we_o,
  output logic [IDX_W-1:0]    fq_waddr_o,
  output logic [IDX_W-1:0]    fq_wdata_o,
  output logic                fq_re_o,
  output logic [IDX_W-1:0]    fq_raddr_o,
  input  logic [IDX_W-1:0]    fq_rdata_i
);

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [GEN_BITS-1:0] gen_q, gen_d;
  logic [CNT_W-1:0]    siu_q, siu_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    fcnt_q, fcnt_d;
  logic [IDX_W-1:0]    ptr_q, ptr_d;
  result_t             res_q, res_d;

  logic             full;
  logic             reuse;
  logic             in_range;
  logic             gen_ok;
  logic             scan_last;
  logic [CNT_W-1:0] ptr_next;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_next;

  assign full      = (siu_q == CNT_W'(SLOT_COUNT));
  assign reuse     = full || (fcnt_q > CNT_W'(thr_i));
  assign in_range  = ({1'b0, idx_q} < siu_q);
  assign gen_ok    = slot_rdata_i.live && (slot_rdata_i.gen == gen_q);
  assign ptr_next  = {1'b0, ptr_q} + CNT_W'(1);
  assign scan_last = (ptr_next >= siu_q);
  assign head_next = (head_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : head_q + IDX_W'(1);
  assign tail_next = (tail_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : tail_q + IDX_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (cmd_q == CMD_CREATE) begin
          if (reuse && (fcnt_q != '0)) state_d = S_FQ_WAIT;
          else state_d = S_RESULT;
        end else if (!in_range) begin
          state_d = S_RESULT;
        end else if (cmd_q == CMD_FIND) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_FQ_WAIT: state_d = S_REUSE;
      S_REUSE:   state_d = S_RESULT;
      S_CHECK:   state_d = S_RESULT;
      S_SCAN: begin
        if (slot_rdata_i.live || scan_last) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    gen_d        = gen_q;
    siu_d        = siu_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fcnt_d       = fcnt_q;
    ptr_d        = ptr_q;
    res_d        = res_q;
    req_ready_o  = 1'b0;
    res_valid_o  = 1'b0;
    slot_we_o    = 1'b0;
    slot_waddr_o = idx_q;
    slot_wdata_o = '0;
    slot_re_o    = 1'b0;
    slot_raddr_o = idx_q;
    fq_we_o      = 1'b0;
    fq_waddr_o   = tail_q;
    fq_wdata_o   = idx_q;
    fq_re_o      = 1'b0;
    fq_raddr_o   = head_q;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d = cmd_e'(req_cmd_i);
          idx_d = req_index_i;
          gen_d = req_gen_i;
        end
      end
      S_DECODE: begin
        res_d = '{status: STAT_OK, generation: '0, index: '0};
        if (cmd_q == CMD_CREATE) begin
          if (reuse) begin
            if (fcnt_q == '0) begin
              res_d.status = STAT_FAIL;
            end else begin
              fq_re_o = 1'b1;
            end
          end else begin
            slot_we_o    = 1'b1;
            slot_waddr_o = siu_q[IDX_W-1:0];
            slot_wdata_o = '{live: 1'b1, gen: '0};
            siu_d        = siu_q + CNT_W'(1);
            res_d.index  = siu_q[IDX_W-1:0];
          end
        end else if (!in_range) begin
          res_d.status = STAT_RANGE;
        end else begin
          slot_re_o    = 1'b1;
          slot_raddr_o = idx_q;
          ptr_d        = idx_q;
        end
      end
      S_FQ_WAIT: begin
        ptr_d        = fq_rdata_i;
        slot_re_o    = 1'b1;
        slot_raddr_o = fq_rdata_i;
        head_d       = head_next;
        fcnt_d       = fcnt_q - CNT_W'(1);
      end
      S_REUSE: begin
        slot_we_o        = 1'b1;
        slot_waddr_o     = ptr_q;
        slot_wdata_o     = '{live: 1'b1, gen: slot_rdata_i.gen};
        res_d.index      = ptr_q;
        res_d.generation = slot_rdata_i.gen;
      end
      S_CHECK: begin
        if (!gen_ok) begin
          res_d.status = STAT_STALE;
        end else if (cmd_q == CMD_DESTROY) begin
          slot_we_o    = 1'b1;
          slot_waddr_o = idx_q;
          slot_wdata_o = '{live: 1'b0, gen: slot_rdata_i.gen + GEN_BITS'(1)};
          fq_we_o      = 1'b1;
          tail_d       = tail_next;
          fcnt_d       = fcnt_q + CNT_W'(1);
        end
      end
      S_SCAN: begin
        if (slot_rdata_i.live) begin
          res_d.index      = ptr_q;
          res_d.generation = slot_rdata_i.gen;
        end else if (scan_last) begin
          res_d.status = STAT_FAIL;
        end else begin
          ptr_d        = ptr_next[IDX_W-1:0];
          slot_re_o    = 1'b1;
          slot_raddr_o = ptr_next[IDX_W-1:0];
        end
      end
      S_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      siu_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      fcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      siu_q   <= siu_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fcnt_q  <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    gen_q <= gen_d;
    ptr_q <= ptr_d;
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_fcnt_le_siu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= siu_q)
    else $error("free count exceeds slots in use");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ({1'b0, ptr_q} < siu_q))
    else $error("scan pointer beyond slots in use");

  a_fq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_we_o |-> (fcnt_q < CNT_W'(SLOT_COUNT)))
    else $error("free queue push when full");

  a_fresh_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE && slot_we_o) |=> (siu_q == $past(siu_q) + CNT_W'(1)))
    else $error("fresh create did not advance slots in use");
`endif

endmodule

[src/generational_slot_allocator.sv]
// generational_slot_allocator: top level of the slot allocator
// holds the threshold register and result register; uses gsa_pkg, gsa_ram, gsa_ctrl
//
// requests enter on the s_axis channel: tuser carries the command (create,
// destroy, exists, find next live slot), tdata the slot index and generation.
// each request gives one result on the m_axis channel: index, generation and
// status. one request is worked on at a time; a new one is taken only after
// the last result has moved on. states: fresh create decode, result; reuse
// decode, free-queue wait, reuse, result; destroy and exists decode, check,
// result; find-next decode, one scan step per slot (the slot ram gives one
// entry per cycle), result; out-of-range and failed create decode, result.
// reset clears the counters and queue pointers and loads the reuse threshold
// with 512; slot state beyond the slots-in-use count is never read, so no
// clearing pass follows reset. the user writes the threshold through cfg_we_i
// only while the block is idle, which the block does not enforce. a stalled
// receiver holds the result register; the next request is still taken and
// waits in the sequencer's own result register until the output drains.
module generational_slot_allocator import gsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // index[11:0], generation[27:12], zero pad
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // index[11:0], generation[27:12], status[29:28]
);

  localparam int ResW = $bits(result_t);

  logic [THR_W-1:0] thr_q;
  logic             out_valid_q;
  result_t          out_q;

  logic             res_valid;
  logic             res_ready;
  result_t          res;

  logic             slot_we;
  logic [IDX_W-1:0] slot_waddr;
  slot_word_t       slot_wdata;
  logic             slot_re;
  logic [IDX_W-1:0] slot_raddr;
  slot_word_t       slot_rdata;
  logic             fq_we;
  logic [IDX_W-1:0] fq_waddr;
  logic [IDX_W-1:0] fq_wdata;
  logic             fq_re;
  logic [IDX_W-1:0] fq_raddr;
  logic [IDX_W-1:0] fq_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(32 - ResW){1'b0}}, out_q};

  gsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thr_i        (thr_q),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_cmd_i    (s_axis_tuser),
    .req_index_i  (s_axis_tdata[IDX_W-1:0]),
    .req_gen_i    (s_axis_tdata[IDX_W+GEN_BITS-1:IDX_W]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .slot_we_o    (slot_we),
    .slot_waddr_o (slot_waddr),
    .slot_wdata_o (slot_wdata),
    .slot_re_o    (slot_re),
    .slot_raddr_o (slot_raddr),
    .slot_rdata_i (slot_rdata),
    .fq_we_o      (fq_we),
    .fq_waddr_o   (fq_waddr),
    .fq_wdata_o   (fq_wdata),
    .fq_re_o      (fq_re),
    .fq_raddr_o   (fq_raddr),
    .fq_rdata_i   (fq_rdata)
  );

  gsa_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH ($bits(slot_word_t))
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  gsa_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (IDX_W)
  ) u_fq_ram (
    .clk_i   (clk_i),
    .we_i    (fq_we),
    .waddr_i (fq_waddr),
    .wdata_i (fq_wdata),
    .re_i    (fq_re),
    .raddr_i (fq_raddr),
    .rdata_o (fq_rdata)
  );

endmodule
